@@ rtl/rsd_pkg.sv @@
// rsd_pkg: shared types, codes and the RGBE to binary32 conversion
// for the RGBE scanline run-length decoder. No dependencies.
package rsd_pkg;

  localparam int RUN_BIAS   = 128;
  localparam int EXP_OFFSET = 136 - 127;
  localparam logic [7:0] HDR_MAGIC = 8'd2;

  localparam logic [1:0] KIND_LINE  = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_HEADER   = 3'd1;
  localparam logic [2:0] ERR_OVERFLOW = 3'd2;
  localparam logic [2:0] ERR_TRUNC    = 3'd3;
  localparam logic [2:0] ERR_BUSY     = 3'd4;

  typedef struct packed {
    logic       is_read;
    logic [7:0] data;
    logic       eod;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_READ,
    ST_EMIT
  } eng_state_t;

  // exact binary32 of m * 2^(e-136), +0 when m or e is zero
  function automatic logic [31:0] rgbe_bits(logic [7:0] m, logic [7:0] e);
    logic [2:0]  p;
    logic [8:0]  se;
    logic [31:0] sh;
    logic [31:0] r;
    p = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (m[i]) p = 3'(i);
    end
    se = 9'(p) + 9'(e);
    sh = 32'(m) << (5'd23 - 5'(p));
    if (m == 8'd0 || e == 8'd0) begin
      r = 32'd0;
    end else if (se >= 9'(EXP_OFFSET + 1)) begin
      r = {1'b0, 8'(se - 9'(EXP_OFFSET)), sh[22:0]};
    end else begin
      r = 32'(m) << (e[4:0] + 5'd13);
    end
    return r;
  endfunction

endpackage

@@ rtl/rsd_ram.sv @@
// rsd_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module rsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

@@ rtl/rsd_front.sv @@
// rsd_front: accepts items, classifies them and holds them in a
// two-entry queue for the engine. Depends on rsd_pkg.
module rsd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_opcode,
  input  logic [7:0]    in_data_byte,
  input  logic          in_end_of_data,
  output logic          itm_valid,
  output rsd_pkg::item_t itm,
  input  logic          itm_pop
);
  import rsd_pkg::*;

  item_t      q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign itm_valid = (cnt_r != 2'd0);
  assign itm       = q_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ (itm_pop && itm_valid);
    cnt_nxt = cnt_r + 2'(push) - 2'(itm_pop && itm_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) q_r[wp_r] <= '{is_read: in_opcode, data: in_data_byte, eod: in_end_of_data};
  end
endmodule

@@ rtl/rsd_engine.sv @@
// rsd_engine: decodes stream bytes into the scanline store, drains pixels
// and owns the result register. Depends on rsd_pkg and rsd_ram.
module rsd_engine #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [14:0]    cfg_wdata,
  input  logic           itm_valid,
  input  rsd_pkg::item_t itm,
  output logic           itm_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_kind,
  output logic [2:0]     out_error_code,
  output logic [31:0]    out_red_bits,
  output logic [31:0]    out_green_bits,
  output logic [31:0]    out_blue_bits,
  output logic [11:0]    out_pixel_x,
  output logic [14:0]    out_line_y,
  output logic           out_last_in_line
);
  import rsd_pkg::*;

  localparam int DEPTH = 4 * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  eng_state_t st_r, st_nxt;
  logic [12:0] width_r;
  logic [14:0] height_r;
  logic [2:0]  hdr_r, hdr_nxt;
  logic [7:0]  wh_r, wh_nxt;
  logic [1:0]  ch_r, ch_nxt;
  logic [12:0] col_r, col_nxt;
  logic [7:0]  lit_r, lit_nxt;
  logic [6:0]  runp_r, runp_nxt;
  logic [14:0] line_r, line_nxt;
  logic [12:0] drain_r, drain_nxt;
  logic        rdy_r, rdy_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [1:0]  fch_r, fch_nxt;
  logic [12:0] fcol_r, fcol_nxt;
  logic [6:0]  fleft_r, fleft_nxt;
  logic [7:0]  fval_r, fval_nxt;
  logic [2:0]  rcnt_r, rcnt_nxt;
  logic [7:0]  pix_r [4];

  logic        ov_r, ov_nxt;
  logic [1:0]  ok_r, ok_nxt;
  logic [2:0]  oe_r, oe_nxt;
  logic [31:0] ored_r, ored_nxt, ogrn_r, ogrn_nxt, oblu_r, oblu_nxt;
  logic [11:0] ox_r, ox_nxt;
  logic [14:0] oy_r, oy_nxt;
  logic        olast_r, olast_nxt;

  logic        slot_free;
  logic        we_c;
  logic [1:0]  wch_c;
  logic [12:0] wcol_c;
  logic [7:0]  wdat_c;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]  rdata;
  logic [2:0]  ecode;
  logic        lr_emit;
  logic [13:0] sum;
  logic        ovf;
  logic [7:0]  b;

  assign slot_free = !ov_r || out_ready;

  rsd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk(clk), .we(we_c && (32'(wcol_c) < 32'(MAX_WIDTH))), .waddr(waddr),
    .wdata(wdat_c), .raddr(raddr), .rdata(rdata)
  );

  assign waddr = AW'(32'(wch_c) * 32'(MAX_WIDTH) + 32'(wcol_c));
  assign raddr = AW'(32'(rcnt_r[1:0]) * 32'(MAX_WIDTH) + 32'(drain_r));

  always_comb begin
    st_nxt = st_r; hdr_nxt = hdr_r; wh_nxt = wh_r; ch_nxt = ch_r; col_nxt = col_r;
    lit_nxt = lit_r; runp_nxt = runp_r; line_nxt = line_r; drain_nxt = drain_r;
    rdy_nxt = rdy_r; err_nxt = err_r; fch_nxt = fch_r; fcol_nxt = fcol_r;
    fleft_nxt = fleft_r; fval_nxt = fval_r; rcnt_nxt = rcnt_r;
    ov_nxt = ov_r && !out_ready; ok_nxt = ok_r; oe_nxt = oe_r; ored_nxt = ored_r;
    ogrn_nxt = ogrn_r; oblu_nxt = oblu_r; ox_nxt = ox_r; oy_nxt = oy_r;
    olast_nxt = olast_r;
    itm_pop = 1'b0; we_c = 1'b0; wch_c = ch_r; wcol_c = col_r; wdat_c = itm.data;
    ecode = ERR_NONE; lr_emit = 1'b0; sum = 14'd0; ovf = 1'b0; b = itm.data;
    case (st_r)
      ST_IDLE: begin
        if (itm_valid && slot_free) begin
          itm_pop = 1'b1;
          if (err_r != ERR_NONE) begin
            ecode = err_r;
          end else if (itm.is_read) begin
            if (rdy_r) begin
              rcnt_nxt = 3'd0;
              st_nxt = ST_READ;
            end
          end else if (rdy_r) begin
            ecode = ERR_BUSY;
          end else if (line_r >= height_r) begin
            ecode = ERR_NONE;
          end else if (hdr_r < 3'd3) begin
            if (itm.eod) ecode = ERR_TRUNC;
            else if (hdr_r < 3'd2 && b != HDR_MAGIC) ecode = ERR_HEADER;
            else begin
              if (hdr_r == 3'd2) wh_nxt = b;
              hdr_nxt = hdr_r + 3'd1;
            end
          end else if (hdr_r == 3'd3) begin
            if ({wh_r, b} != {3'd0, width_r} || width_r == 13'd0 ||
                32'(width_r) > 32'(MAX_WIDTH)) begin
              ecode = ERR_HEADER;
            end else begin
              hdr_nxt = 3'd4; ch_nxt = 2'd0; col_nxt = 13'd0;
              lit_nxt = 8'd0; runp_nxt = 7'd0;
              if (itm.eod) ecode = ERR_TRUNC;
            end
          end else begin
            if (lit_r != 8'd0) begin
              we_c = 1'b1;
              col_nxt = col_r + 13'd1;
              lit_nxt = lit_r - 8'd1;
            end else if (runp_r != 7'd0) begin
              // write the first entry now, sweep the rest in fill
              we_c = 1'b1;
              col_nxt = col_r + 13'(runp_r);
              runp_nxt = 7'd0;
              if (runp_r > 7'd1) begin
                fch_nxt = ch_r; fcol_nxt = col_r + 13'd1;
                fleft_nxt = runp_r - 7'd1; fval_nxt = b;
                st_nxt = ST_FILL;
              end
            end else if (b > 8'(RUN_BIAS)) begin
              sum = 14'(col_r) + 14'(b - 8'(RUN_BIAS));
              if (sum > 14'(width_r)) ovf = 1'b1;
              else runp_nxt = 7'(b - 8'(RUN_BIAS));
            end else begin
              sum = 14'(col_r) + 14'(b);
              if (sum > 14'(width_r)) ovf = 1'b1;
              else lit_nxt = b;
            end
            if (ovf) begin
              ecode = ERR_OVERFLOW;
            end else begin
              if (lit_nxt == 8'd0 && runp_nxt == 7'd0 && col_nxt >= width_r) begin
                col_nxt = 13'd0;
                if (ch_r == 2'd3) begin
                  hdr_nxt = 3'd0; ch_nxt = 2'd0;
                  if (itm.eod && (16'(line_r) + 16'd1 < 16'(height_r))) begin
                    ecode = ERR_TRUNC;
                  end else begin
                    rdy_nxt = 1'b1; drain_nxt = 13'd0; lr_emit = 1'b1;
                  end
                end else begin
                  ch_nxt = ch_r + 2'd1;
                end
              end
              if (itm.eod && !lr_emit && ecode == ERR_NONE) ecode = ERR_TRUNC;
            end
          end
          if (ecode != ERR_NONE) begin
            err_nxt = ecode; ov_nxt = 1'b1; ok_nxt = KIND_ERROR; oe_nxt = ecode;
            ored_nxt = '0; ogrn_nxt = '0; oblu_nxt = '0; ox_nxt = '0; oy_nxt = '0;
            olast_nxt = 1'b0;
          end else if (lr_emit) begin
            ov_nxt = 1'b1; ok_nxt = KIND_LINE; oe_nxt = ERR_NONE;
            ored_nxt = '0; ogrn_nxt = '0; oblu_nxt = '0; ox_nxt = '0; oy_nxt = line_r;
            olast_nxt = 1'b0;
          end
        end
      end
      ST_FILL: begin
        we_c = 1'b1; wch_c = fch_r; wcol_c = fcol_r; wdat_c = fval_r;
        fcol_nxt = fcol_r + 13'd1;
        fleft_nxt = fleft_r - 7'd1;
        if (fleft_r == 7'd1) st_nxt = ST_IDLE;
      end
      ST_READ: begin
        rcnt_nxt = rcnt_r + 3'd1;
        if (rcnt_r == 3'd4) st_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          ov_nxt = 1'b1; ok_nxt = KIND_PIXEL; oe_nxt = ERR_NONE;
          ored_nxt = rgbe_bits(pix_r[0], pix_r[3]);
          ogrn_nxt = rgbe_bits(pix_r[1], pix_r[3]);
          oblu_nxt = rgbe_bits(pix_r[2], pix_r[3]);
          ox_nxt = drain_r[11:0]; oy_nxt = line_r;
          olast_nxt = (14'(drain_r) + 14'd1 >= 14'(width_r));
          if (olast_nxt) begin
            rdy_nxt = 1'b0; drain_nxt = 13'd0; line_nxt = line_r + 15'd1;
          end else begin
            drain_nxt = drain_r + 13'd1;
          end
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; width_r <= 13'd64; height_r <= 15'd64;
      hdr_r <= '0; wh_r <= '0; ch_r <= '0; col_r <= '0; lit_r <= '0; runp_r <= '0;
      line_r <= '0; drain_r <= '0; rdy_r <= 1'b0; err_r <= ERR_NONE;
      fleft_r <= '0; rcnt_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we && cfg_index == 1'b0) width_r <= cfg_wdata[12:0];
      if (cfg_we && cfg_index == 1'b1) height_r <= cfg_wdata;
      hdr_r <= hdr_nxt; wh_r <= wh_nxt; ch_r <= ch_nxt; col_r <= col_nxt;
      lit_r <= lit_nxt; runp_r <= runp_nxt; line_r <= line_nxt; drain_r <= drain_nxt;
      rdy_r <= rdy_nxt; err_r <= err_nxt; fleft_r <= fleft_nxt; rcnt_r <= rcnt_nxt;
      ov_r <= ov_nxt;
    end
    fch_r <= fch_nxt; fcol_r <= fcol_nxt; fval_r <= fval_nxt;
    ok_r <= ok_nxt; oe_r <= oe_nxt; ored_r <= ored_nxt; ogrn_r <= ogrn_nxt;
    oblu_r <= oblu_nxt; ox_r <= ox_nxt; oy_r <= oy_nxt; olast_r <= olast_nxt;
    if (st_r == ST_READ && rcnt_r != 3'd0) pix_r[rcnt_r[1:0] - 2'd1] <= rdata;
  end

  assign out_valid = ov_r;
  assign out_kind = ok_r;
  assign out_error_code = oe_r;
  assign out_red_bits = ored_r;
  assign out_green_bits = ogrn_r;
  assign out_blue_bits = oblu_r;
  assign out_pixel_x = ox_r;
  assign out_line_y = oy_r;
  assign out_last_in_line = olast_r;

  a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_FILL |-> fleft_r != 7'd0) else $error("fill with no entries left");
  a_ready_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    rdy_r |-> hdr_r == 3'd0) else $error("line ready mid header");
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    itm_pop && err_r != ERR_NONE |=> ov_r && ok_r == KIND_ERROR)
    else $error("sticky error not reported");
  a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != ERR_NONE |=> $stable(err_r)) else $error("error code changed");
endmodule

@@ rtl/rgbe_scanline_rle_decoder.sv @@
// rgbe_scanline_rle_decoder: top level of the RGBE adaptive run-length
// scanline decoder. Depends on rsd_pkg, rsd_front, rsd_engine, rsd_ram.
//
// Usage:
//   in_*  : valid/ready channel. in_opcode 0 carries one compressed byte
//           (in_data_byte, in_end_of_data), opcode 1 asks for the next pixel
//           of the decoded line.
//   out_* : valid/ready channel, at most one result per item: line ready,
//           pixel (binary32 r, g, b) or a sticky error code.
//   cfg_* : write port; index 0 is image_width, index 1 is image_height.
//           Write only while no item is in flight.
// Flow: a two-entry queue in front of the engine registers each item before
//   the engine takes it. The byte after a run count sweeps its repeated entries
//   (up to 127) through the fill state, since the scanline store has one write
//   port. A pixel read takes the item, makes four reads of the store's single
//   read port, captures the last read data and then converts it, waiting in
//   the emit state while the result register is full.
// Reset (rst_n low, synchronous) clears all control state and errors; the
//   store is not cleared. When the receiver stalls, the result register
//   holds and the engine waits; the queue keeps taking items until full.
module rgbe_scanline_rle_decoder #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [14:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_error_code,
  output logic [31:0] out_red_bits,
  output logic [31:0] out_green_bits,
  output logic [31:0] out_blue_bits,
  output logic [11:0] out_pixel_x,
  output logic [14:0] out_line_y,
  output logic        out_last_in_line
);
  import rsd_pkg::*;

  item_t itm;
  logic  itm_valid, itm_pop;

  // front: accept and queue items
  rsd_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_opcode), .in_data_byte(in_data_byte),
    .in_end_of_data(in_end_of_data), .itm_valid(itm_valid), .itm(itm),
    .itm_pop(itm_pop)
  );

  // back: decode, store, drain
  rsd_engine #(.MAX_WIDTH(MAX_WIDTH)) u_engine (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .itm_valid(itm_valid), .itm(itm), .itm_pop(itm_pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_error_code(out_error_code), .out_red_bits(out_red_bits),
    .out_green_bits(out_green_bits), .out_blue_bits(out_blue_bits),
    .out_pixel_x(out_pixel_x), .out_line_y(out_line_y),
    .out_last_in_line(out_last_in_line)
  );
endmodule
